@@ sv/ffrd_pkg.sv @@
package ffrd_pkg;

  // frame store geometry
  localparam int MAX_FRAME_BYTES = 64;
  localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);
  localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);

  // link constants
  localparam logic [7:0] TERM_BYTE = 8'hFF;
  localparam logic [1:0] LAST_TERM_COUNT = 2'd2;
  localparam logic [LEN_W-1:0] NUMBER_FRAME_LEN = LEN_W'(5);

  // frame class codes
  localparam logic [2:0] CLS_RETURN  = 3'd0;
  localparam logic [2:0] CLS_TOUCH   = 3'd1;
  localparam logic [2:0] CLS_NUMBER  = 3'd2;
  localparam logic [2:0] CLS_STRING  = 3'd3;
  localparam logic [2:0] CLS_DISCARD = 3'd4;

  // first-byte codes
  localparam logic [7:0] CODE_TOUCH  = 8'h65;
  localparam logic [7:0] CODE_NUMBER = 8'h71;
  localparam logic [7:0] CODE_STRING = 8'h70;

  // command from front to back: a store write or a frame close
  typedef struct packed {
    logic              is_close;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic [LEN_W-1:0]  len;
    logic [2:0]        cls;
    logic [31:0]       num;
    logic              nvalid;
    logic              trunc;
  } cmd_t;

  // back-end drain states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } drain_state_t;

  // class lookup from the first byte of a frame
  function automatic logic [2:0] class_of(input logic [7:0] code);
    logic [2:0] cls;
    case (code)
      CODE_TOUCH:  cls = CLS_TOUCH;
      CODE_NUMBER: cls = CLS_NUMBER;
      CODE_STRING: cls = CLS_STRING;
      8'h00, 8'h66, 8'h67, 8'h68,
      8'h86, 8'h87, 8'h88, 8'h89,
      8'hFD, 8'hFE, 8'hFF: cls = CLS_DISCARD;
      default:     cls = CLS_RETURN;
    endcase
    return cls;
  endfunction

endpackage

@@ sv/ffrd_front.sv @@
module ffrd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          rx_byte,
  input  logic                q_full,
  output logic                q_push,
  output ffrd_pkg::cmd_t      q_cmd
);

  logic [1:0]                   term_count;
  logic [ffrd_pkg::LEN_W-1:0]   frame_length;
  logic                         overflow_seen;
  logic [2:0]                   cls;
  logic [31:0]                  num;

  logic accept;
  logic is_term;
  logic has_room;
  logic closing;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_term  = (rx_byte == ffrd_pkg::TERM_BYTE);
  assign has_room = (frame_length < ffrd_pkg::LEN_W'(ffrd_pkg::MAX_FRAME_BYTES));
  assign closing  = is_term && (term_count == ffrd_pkg::LAST_TERM_COUNT);

  // command to the back end
  always_comb begin
    q_cmd          = '0;
    q_cmd.addr     = frame_length[ffrd_pkg::ADDR_W-1:0];
    q_cmd.data     = rx_byte;
    q_cmd.len      = frame_length;
    q_cmd.cls      = cls;
    q_cmd.num      = num;
    q_cmd.nvalid   = (cls == ffrd_pkg::CLS_NUMBER) &&
                     (frame_length == ffrd_pkg::NUMBER_FRAME_LEN);
    q_cmd.trunc    = overflow_seen;
    q_cmd.is_close = is_term;
    q_push         = 1'b0;
    if (accept) begin
      if (!is_term) begin
        q_push = has_room;
      end else begin
        q_push = closing && (frame_length != '0);
      end
    end
  end

  // frame bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      term_count    <= '0;
      frame_length  <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (!is_term) begin
        if (has_room) begin
          frame_length <= frame_length + 1'b1;
        end else begin
          overflow_seen <= 1'b1;
        end
      end else if (closing) begin
        term_count    <= '0;
        frame_length  <= '0;
        overflow_seen <= 1'b0;
      end else begin
        term_count <= term_count + 1'b1;
      end
    end
  end

  // class and number capture from the leading bytes
  always_ff @(posedge clk) begin
    if (accept && !is_term && has_room) begin
      case (frame_length)
        ffrd_pkg::LEN_W'(0): cls <= ffrd_pkg::class_of(rx_byte);
        ffrd_pkg::LEN_W'(1): num[7:0]   <= rx_byte;
        ffrd_pkg::LEN_W'(2): num[15:8]  <= rx_byte;
        ffrd_pkg::LEN_W'(3): num[23:16] <= rx_byte;
        ffrd_pkg::LEN_W'(4): num[31:24] <= rx_byte;
        default: ;
      endcase
    end
  end

endmodule

@@ sv/ffrd_queue.sv @@
module ffrd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ffrd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output ffrd_pkg::cmd_t head
);

  ffrd_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ sv/ffrd_back.sv @@
module ffrd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  ffrd_pkg::cmd_t             q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 frame_class,
  output logic [7:0]                 payload_byte,
  output logic [5:0]                 byte_index,
  output logic                       last,
  output logic [31:0]                number_value,
  output logic                       number_valid,
  output logic                       truncated
);

  ffrd_pkg::drain_state_t state;
  ffrd_pkg::drain_state_t state_next;

  logic [7:0]                  frame_store [ffrd_pkg::MAX_FRAME_BYTES];
  logic [7:0]                  rd_data;
  logic [ffrd_pkg::ADDR_W-1:0] idx;
  ffrd_pkg::cmd_t              desc;

  logic is_last;
  logic start;
  logic advance;

  assign is_last = (ffrd_pkg::LEN_W'(idx) == ffrd_pkg::LEN_W'(desc.len - 1'b1));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffrd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_valid  = 1'b0;
    start      = 1'b0;
    advance    = 1'b0;
    case (state)
      ffrd_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.is_close) begin
            start      = 1'b1;
            state_next = ffrd_pkg::ST_READ;
          end
        end
      end
      ffrd_pkg::ST_READ: begin
        state_next = ffrd_pkg::ST_SHOW;
      end
      ffrd_pkg::ST_SHOW: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (is_last) begin
            state_next = ffrd_pkg::ST_IDLE;
          end else begin
            advance    = 1'b1;
            state_next = ffrd_pkg::ST_READ;
          end
        end
      end
      default: state_next = ffrd_pkg::ST_IDLE;
    endcase
  end

  // frame store write and registered read
  always_ff @(posedge clk) begin
    if (q_pop && !q_head.is_close) begin
      frame_store[q_head.addr] <= q_head.data;
    end
    rd_data <= frame_store[idx];
  end

  // drain index and frame descriptor
  always_ff @(posedge clk) begin
    if (start) begin
      desc <= q_head;
      idx  <= '0;
    end else if (advance) begin
      idx <= idx + 1'b1;
    end
  end

  // result fields
  assign frame_class  = desc.cls;
  assign payload_byte = rd_data;
  assign byte_index   = 6'(idx);
  assign last         = is_last;
  assign number_valid = is_last && desc.nvalid;
  assign number_value = number_valid ? desc.num : 32'd0;
  assign truncated    = desc.trunc;

endmodule

@@ sv/ff_terminated_response_deframer_core.sv @@
// Display-link response deframer.
// Input channel: one received byte per transaction on rx_byte (in_valid /
// in_stall). A byte other than 0xFF is stored; a 0xFF is counted and the
// third one closes the frame.
// Output channel: one transaction per stored byte of a closed frame (out_valid
// / out_stall), in order, with the frame class, byte index, last flag, the
// 32-bit value of a five-byte number frame on its last byte, and a truncation
// flag. Empty frames give no output.
// Throughput: the front takes one byte per cycle while the two-entry command
// queue has room. The back end drains a closed frame one result at a time
// (registered frame store read, then show); store writes queued behind
// a close wait for the drain, so a long drain backs up into in_stall.
// Output path: with the back end idle, the close is popped from the queue in
// ST_IDLE, the first byte is read in ST_READ, and out_valid rises in ST_SHOW.
// Reset (rst, synchronous): clears terminator count, frame length, overflow
// flag, queue and drain state. The store itself is not cleared.
// A stalled output holds its fields until taken.
module ff_terminated_response_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  frame_class,
  output logic [7:0]  payload_byte,
  output logic [5:0]  byte_index,
  output logic        last,
  output logic [31:0] number_value,
  output logic        number_valid,
  output logic        truncated
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  ffrd_pkg::cmd_t q_cmd;
  ffrd_pkg::cmd_t q_head;

  // byte intake and classification
  ffrd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // command queue between front and back
  ffrd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // frame store and drain
  ffrd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_class  (frame_class),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .last         (last),
    .number_value (number_value),
    .number_valid (number_valid),
    .truncated    (truncated)
  );

endmodule

@@ verif/tb_ff_terminated_response_deframer_core.sv @@
`timescale 1ns / 100ps

module tb_ff_terminated_response_deframer_core;

  localparam int TERMS_TO_CLOSE = 3;
  localparam int NUMBER_LEN = 5;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS = 100;
  localparam int TAIL_CYCLES = 20;
  // first-byte codes that mark a frame for discard; the terminator code is last
  localparam logic [7:0] DISCARD_CODES [11] = '{
    8'h00, 8'h66, 8'h67, 8'h68, 8'h86, 8'h87, 8'h88, 8'h89, 8'hFD, 8'hFE, 8'hFF
  };

  typedef struct packed {
    logic [2:0]  cls;
    logic [7:0]  data;
    logic [5:0]  idx;
    logic        last;
    logic [31:0] num;
    logic        nvalid;
    logic        trunc;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  frame_class;
  logic [7:0]  payload_byte;
  logic [5:0]  byte_index;
  logic        last;
  logic [31:0] number_value;
  logic        number_valid;
  logic        truncated;

  // deframer state as predicted
  int          seen_terms = 0;
  logic [7:0]  held_bytes [ffrd_pkg::MAX_FRAME_BYTES];
  int          held_len = 0;
  logic        held_dropped = 1'b0;
  frame_byte_t pending_frame_bytes [$];

  int          mismatch_count = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  bit          src_gaps_on = 1'b0;
  bit          sink_stalls_on = 1'b0;
  int          sink_hold_cycles = 0;
  int          stall_run = 0;

  ff_terminated_response_deframer_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_class  (frame_class),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .last         (last),
    .number_value (number_value),
    .number_valid (number_valid),
    .truncated    (truncated)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // gap length: mostly none or short, now and then long
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [2:0] class_for_code(input logic [7:0] code);
    if (code == ffrd_pkg::CODE_TOUCH) return ffrd_pkg::CLS_TOUCH;
    if (code == ffrd_pkg::CODE_NUMBER) return ffrd_pkg::CLS_NUMBER;
    if (code == ffrd_pkg::CODE_STRING) return ffrd_pkg::CLS_STRING;
    foreach (DISCARD_CODES[k])
      if (code == DISCARD_CODES[k]) return ffrd_pkg::CLS_DISCARD;
    return ffrd_pkg::CLS_RETURN;
  endfunction

  // mostly table codes, the rest any storable byte
  function automatic logic [7:0] random_code();
    case ($urandom_range(0, 5))
      0: return ffrd_pkg::CODE_TOUCH;
      1: return ffrd_pkg::CODE_NUMBER;
      2: return ffrd_pkg::CODE_STRING;
      3: return DISCARD_CODES[$urandom_range(0, 9)];
      default: return 8'($urandom_range(0, 254));
    endcase
  endfunction

  // advance the predicted state by one received byte
  task automatic predict_rx(input logic [7:0] b);
    logic [2:0]  cls;
    logic        nvalid;
    logic [31:0] num;
    frame_byte_t fb;
    int          i;
    if (b != ffrd_pkg::TERM_BYTE) begin
      if (held_len < ffrd_pkg::MAX_FRAME_BYTES) begin
        held_bytes[held_len] = b;
        held_len++;
      end else begin
        held_dropped = 1'b1;
      end
    end else begin
      seen_terms++;
      if (seen_terms == TERMS_TO_CLOSE) begin
        // empty frames produce nothing
        if (held_len > 0) begin
          cls = class_for_code(held_bytes[0]);
          nvalid = (cls == ffrd_pkg::CLS_NUMBER) && (held_len == NUMBER_LEN);
          num = '0;
          if (nvalid) num = {held_bytes[4], held_bytes[3], held_bytes[2], held_bytes[1]};
          for (i = 0; i < held_len; i++) begin
            fb.cls    = cls;
            fb.data   = held_bytes[i];
            fb.idx    = 6'(i);
            fb.last   = (i == held_len - 1);
            fb.num    = fb.last ? num : '0;
            fb.nvalid = fb.last && nvalid;
            fb.trunc  = held_dropped;
            pending_frame_bytes = {pending_frame_bytes, fb};
          end
        end
        seen_terms = 0;
        held_len = 0;
        held_dropped = 1'b0;
      end
    end
  endtask

  // one input transaction; entered and left at a falling edge
  task automatic send_rx(input logic [7:0] b);
    int gap;
    gap = src_gaps_on ? random_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_rx(b);
    items_sent++;
    @(negedge clk);
  endtask

  // a frame of len data bytes; with spread, up to two terminators may fall among the data
  task automatic send_frame(input logic [7:0] code, input int len, input bit spread);
    int i;
    int ff_left;
    ff_left = TERMS_TO_CLOSE;
    for (i = 0; i < len; i++) begin
      if (spread && ff_left > 1 && $urandom_range(0, len) == 0) begin
        send_rx(ffrd_pkg::TERM_BYTE);
        ff_left--;
      end
      send_rx(i == 0 ? code : 8'($urandom_range(0, 254)));
    end
    while (ff_left > 0) begin
      send_rx(ffrd_pkg::TERM_BYTE);
      ff_left--;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // receiver: long hold-off on request, else random stall runs
  initial begin
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles--;
        out_stall <= 1'b1;
      end else if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (sink_stalls_on && $urandom_range(0, 3) == 0) stall_run = random_gap();
      end
    end
  end

  // compare each output transaction with the oldest predicted byte
  always @(posedge clk) begin
    frame_byte_t exp;
    if (!rst && out_valid && !out_stall) begin
      if (pending_frame_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected result, payload 0x%02h index %0d",
                                  payload_byte, byte_index));
      end else begin
        exp = pending_frame_bytes.pop_front();
        if (frame_class !== exp.cls)
          report_mismatch($sformatf("frame_class %0d, expected %0d at index %0d",
                                    frame_class, exp.cls, exp.idx));
        if (payload_byte !== exp.data)
          report_mismatch($sformatf("payload_byte 0x%02h, expected 0x%02h at index %0d",
                                    payload_byte, exp.data, exp.idx));
        if (byte_index !== exp.idx)
          report_mismatch($sformatf("byte_index %0d, expected %0d", byte_index, exp.idx));
        if (last !== exp.last)
          report_mismatch($sformatf("last %0b, expected %0b at index %0d",
                                    last, exp.last, exp.idx));
        if (number_value !== exp.num)
          report_mismatch($sformatf("number_value 0x%08h, expected 0x%08h at index %0d",
                                    number_value, exp.num, exp.idx));
        if (number_valid !== exp.nvalid)
          report_mismatch($sformatf("number_valid %0b, expected %0b at index %0d",
                                    number_valid, exp.nvalid, exp.idx));
        if (truncated !== exp.trunc)
          report_mismatch($sformatf("truncated %0b, expected %0b at index %0d",
                                    truncated, exp.trunc, exp.idx));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // every class, an empty frame, spread terminators, byte extremes
  task automatic test_class_codes();
    send_rx(ffrd_pkg::TERM_BYTE);
    send_rx(ffrd_pkg::TERM_BYTE);
    send_rx(ffrd_pkg::TERM_BYTE);
    send_frame(ffrd_pkg::CODE_TOUCH, 1, 1'b0);
    send_rx(ffrd_pkg::CODE_NUMBER);
    send_rx(8'hFE);
    send_rx(ffrd_pkg::TERM_BYTE);
    send_rx(8'h00);
    send_rx(8'h80);
    send_rx(ffrd_pkg::TERM_BYTE);
    send_rx(8'h7F);
    send_rx(ffrd_pkg::TERM_BYTE);
    send_frame(ffrd_pkg::CODE_STRING, 2, 1'b0);
    send_frame(DISCARD_CODES[0], 1, 1'b0);
    send_frame(8'h01, 1, 1'b0);
  endtask

  // number frames one short, exact and one long
  task automatic test_number_lengths();
    send_frame(ffrd_pkg::CODE_NUMBER, NUMBER_LEN - 1, 1'b0);
    send_frame(ffrd_pkg::CODE_NUMBER, NUMBER_LEN, 1'b1);
    send_frame(ffrd_pkg::CODE_NUMBER, NUMBER_LEN + 1, 1'b0);
  endtask

  // exactly full store, then overflowing frames
  task automatic test_full_store();
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    send_frame(ffrd_pkg::CODE_STRING, ffrd_pkg::MAX_FRAME_BYTES, 1'b0);
    send_frame(DISCARD_CODES[0], ffrd_pkg::MAX_FRAME_BYTES + 6, 1'b1);
    send_frame(ffrd_pkg::CODE_NUMBER, ffrd_pkg::MAX_FRAME_BYTES + 1, 1'b0);
  endtask

  // receiver holds off while frames keep coming, so the input backs up
  task automatic test_output_hold_off();
    int i;
    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    sink_hold_cycles = HOLD_OFF_CYCLES;
    for (i = 0; i < 5; i++) send_frame(random_code(), $urandom_range(3, 8), 1'b0);
  endtask

  // mostly well-formed frames with random content, some stray bytes
  task automatic test_random_stream();
    int start;
    int kind;
    int i;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) src_gaps_on = !src_gaps_on;
      if ($urandom_range(0, 7) == 0) sink_stalls_on = !sink_stalls_on;
      kind = $urandom_range(0, 39);
      if (kind < 28) begin
        send_frame(random_code(), $urandom_range(1, 8), $urandom_range(0, 1));
      end else if (kind < 34) begin
        send_frame(ffrd_pkg::CODE_NUMBER, NUMBER_LEN, $urandom_range(0, 1));
      end else if (kind == 34) begin
        send_frame(random_code(),
                   $urandom_range(ffrd_pkg::MAX_FRAME_BYTES - 4,
                                  ffrd_pkg::MAX_FRAME_BYTES + 6),
                   $urandom_range(0, 1));
      end else begin
        // stray bytes, terminators included, to break frame alignment
        for (i = 0; i < $urandom_range(1, 4); i++) send_rx(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_class_codes();
    test_number_lengths();
    test_full_store();
    test_output_hold_off();
    test_random_stream();
    in_valid <= 1'b0;
    while (pending_frame_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
